// ----- hw/rtl/nsdd_pkg.sv -----
// Shared types, register codes and fixed widths of the null-symbol dip detector.
// No dependencies; the other files that use it refer to it by scoped names.
package nsdd_pkg;

  localparam int LEVEL_FRAC   = 17;
  localparam int FRAME_W      = 18;
  localparam int NULL_W       = 16;
  localparam int SHIFT_W      = 5;
  localparam int CNT_W        = 18;
  localparam int ATTEMPT_W    = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 18;
  localparam int EVENT_W      = 3;
  localparam int PHASE_W      = 3;
  localparam int SUM_OUT_W    = 22;
  localparam int LEVEL_OUT_W  = 17;

  localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS = 3'd5;

  localparam logic [FRAME_W-1:0] FRAME_RESET = 18'd196608;
  localparam logic [NULL_W-1:0]  NULL_RESET  = 16'd2656;
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 5'd17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME = 2'd0,
    REG_NULL  = 2'd1,
    REG_SCAN  = 2'd2,
    REG_SHIFT = 2'd3
  } cfg_reg_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE        = 3'd0,
    EV_DIP         = 3'd1,
    EV_END         = 3'd2,
    EV_DIP_TIMEOUT = 3'd3,
    EV_END_TIMEOUT = 3'd4
  } event_t;

  typedef enum logic [4:0] {
    PH_WARM  = 5'b00001,
    PH_FILL  = 5'b00010,
    PH_DIP   = 5'b00100,
    PH_END   = 5'b01000,
    PH_FOUND = 5'b10000
  } phase_t;

  localparam logic [PHASE_W-1:0] CODE_WARM  = 3'd0;
  localparam logic [PHASE_W-1:0] CODE_FILL  = 3'd1;
  localparam logic [PHASE_W-1:0] CODE_DIP   = 3'd2;
  localparam logic [PHASE_W-1:0] CODE_END   = 3'd3;
  localparam logic [PHASE_W-1:0] CODE_FOUND = 3'd4;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_length;
    logic [NULL_W-1:0]  null_length;
    logic               scan_mode;
    logic [SHIFT_W-1:0] level_shift;
  } cfg_t;

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t ph);
    logic [PHASE_W-1:0] code;
    case (ph)
      PH_WARM:  code = CODE_WARM;
      PH_FILL:  code = CODE_FILL;
      PH_DIP:   code = CODE_DIP;
      PH_END:   code = CODE_END;
      PH_FOUND: code = CODE_FOUND;
      default:  code = CODE_FOUND;
    endcase
    return code;
  endfunction

endpackage

// ----- hw/rtl/nsdd_channels.sv -----
// Valid/ready channel interfaces of the null-symbol dip detector.
// Depends on nsdd_pkg for the fixed payload widths.
interface nsdd_in_if #(
  parameter int SAMPLE_WIDTH = 16
) ();
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic signed [SAMPLE_WIDTH-1:0] sample_i;
  logic signed [SAMPLE_WIDTH-1:0] sample_q;

  modport source (output valid, output opcode, output sample_i, output sample_q,
                  input ready);
  modport sink (input valid, input opcode, input sample_i, input sample_q,
                output ready);
endinterface

interface nsdd_out_if ();
  logic                               valid;
  logic                               ready;
  logic [nsdd_pkg::EVENT_W-1:0]       event_res;
  logic                               signal_absent;
  logic [nsdd_pkg::SUM_OUT_W-1:0]     window_sum;
  logic [nsdd_pkg::LEVEL_OUT_W-1:0]   level_out;
  logic [nsdd_pkg::PHASE_W-1:0]       sync_phase;

  modport source (output valid, output event_res, output signal_absent,
                  output window_sum, output level_out, output sync_phase,
                  input ready);
  modport sink (input valid, input event_res, input signal_absent,
                input window_sum, input level_out, input sync_phase,
                output ready);
endinterface

interface nsdd_cfg_if ();
  logic                              valid;
  logic                              ready;
  logic [nsdd_pkg::CFG_IDX_W-1:0]    index;
  logic [nsdd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/nsdd_cell.sv -----
// One cell of the moving-window delay row: holds one L1 norm.
// No dependencies.
module nsdd_cell #(
  parameter int NORM_W = 17
) (
  input  logic              clk,
  input  logic              shift_en,
  input  logic [NORM_W-1:0] d_in,
  output logic [NORM_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (shift_en) begin
      q <= d_in;
    end
  end

endmodule

// ----- hw/rtl/nsdd_norm.sv -----
// Input stage: registers the command and the L1 norm |i|+|q| of each sample beat.
// No package dependencies.
module nsdd_norm #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           opcode,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_q,
  input  logic                           down_ready,
  output logic                           s1_valid,
  output logic                           s1_rearm,
  output logic [SAMPLE_WIDTH:0]          s1_norm
);

  logic [SAMPLE_WIDTH-1:0] mag_i;
  logic [SAMPLE_WIDTH-1:0] mag_q;
  logic [SAMPLE_WIDTH:0]   norm;

  // The most negative code maps onto 2^(SAMPLE_WIDTH-1), read as unsigned.
  assign mag_i = sample_i[SAMPLE_WIDTH-1] ? (~sample_i + 1'b1) : sample_i;
  assign mag_q = sample_q[SAMPLE_WIDTH-1] ? (~sample_q + 1'b1) : sample_q;
  assign norm  = {1'b0, mag_i} + {1'b0, mag_q};

  assign in_ready = !s1_valid || down_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_rearm <= opcode;
      s1_norm  <= norm;
    end
  end

endmodule

// ----- hw/rtl/nsdd_track.sv -----
// Level tracker, window sum, phase sequencer and result register.
// Depends on nsdd_pkg; takes the oldest norm from the end of the cell row.
module nsdd_track #(
  parameter int WINDOW_LENGTH = 50,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  nsdd_pkg::cfg_t                       cfg,
  input  logic                                 scan_clear,
  input  logic                                 s1_valid,
  input  logic                                 s1_rearm,
  input  logic [SAMPLE_WIDTH:0]                s1_norm,
  output logic                                 s1_ready,
  input  logic [SAMPLE_WIDTH:0]                oldest,
  output logic                                 shift_en,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [nsdd_pkg::EVENT_W-1:0]         event_res,
  output logic                                 signal_absent,
  output logic [nsdd_pkg::SUM_OUT_W-1:0]       window_sum,
  output logic [nsdd_pkg::LEVEL_OUT_W-1:0]     level_out,
  output logic [nsdd_pkg::PHASE_W-1:0]         sync_phase
);

  localparam int NORM_W  = SAMPLE_WIDTH + 1;
  localparam int TOTAL_W = SAMPLE_WIDTH + $clog2(WINDOW_LENGTH + 1);
  localparam int LEVEL_W = NORM_W + nsdd_pkg::LEVEL_FRAC;
  localparam int CMP_W   = LEVEL_W + $clog2(3 * WINDOW_LENGTH + 1) + 2;
  localparam logic [CMP_W-1:0] W_MULT  = CMP_W'(WINDOW_LENGTH);
  localparam logic [CMP_W-1:0] W3_MULT = CMP_W'(3 * WINDOW_LENGTH);
  localparam logic [nsdd_pkg::CNT_W-1:0] W_CNT = nsdd_pkg::CNT_W'(WINDOW_LENGTH);

  logic [LEVEL_W-1:0]               level;
  logic [LEVEL_W-1:0]               level_upd;
  logic [LEVEL_W-1:0]               level_next;
  logic [TOTAL_W-1:0]               total;
  logic [TOTAL_W-1:0]               total_upd;
  logic [TOTAL_W-1:0]               total_next;
  logic [TOTAL_W:0]                 t_sum;
  logic [TOTAL_W:0]                 t_slide;
  logic [nsdd_pkg::CNT_W-1:0]       cnt;
  logic [nsdd_pkg::CNT_W-1:0]       cnt_inc;
  logic [nsdd_pkg::CNT_W-1:0]       cnt_next;
  logic [nsdd_pkg::ATTEMPT_W-1:0]   attempt;
  logic [nsdd_pkg::ATTEMPT_W-1:0]   attempt_next;
  logic                             finished;
  logic                             finished_next;
  nsdd_pkg::phase_t                 phase;
  nsdd_pkg::phase_t                 phase_next;
  nsdd_pkg::phase_t                 tst_phase;
  nsdd_pkg::event_t                 tst_ev;
  logic                             tst_clr;
  nsdd_pkg::event_t                 ev;
  logic                             absent;
  logic                             do_fill;
  logic                             dip_go;
  logic                             end_go;
  logic                             adv;
  logic [LEVEL_W-1:0]               norm_scaled;

  assign s1_ready = !out_valid || out_ready;
  assign adv      = s1_valid && s1_ready;
  assign shift_en = adv && !s1_rearm &&
                    (phase == nsdd_pkg::PH_FILL || phase == nsdd_pkg::PH_DIP ||
                     phase == nsdd_pkg::PH_END);

  assign norm_scaled = {s1_norm, {nsdd_pkg::LEVEL_FRAC{1'b0}}};
  assign level_upd   = level - (level >> cfg.level_shift)
                       + (norm_scaled >> cfg.level_shift);

  assign t_sum     = {1'b0, total} + (TOTAL_W + 1)'(s1_norm);
  assign t_slide   = t_sum - (TOTAL_W + 1)'(oldest);
  assign total_upd = (phase == nsdd_pkg::PH_FILL) ? TOTAL_W'(t_sum) : TOTAL_W'(t_slide);
  assign cnt_inc   = cnt + 1'b1;

  // Threshold tests on the updated sum and level, in exact integers.
  assign dip_go = (CMP_W'(total_upd) << (nsdd_pkg::LEVEL_FRAC + 1)) >
                  (CMP_W'(level_upd) * W_MULT);
  assign end_go = (CMP_W'(total_upd) << (nsdd_pkg::LEVEL_FRAC + 2)) <
                  (CMP_W'(level_upd) * W3_MULT);

  always_comb begin
    if (dip_go) begin
      tst_phase = nsdd_pkg::PH_DIP;
      tst_ev    = nsdd_pkg::EV_NONE;
      tst_clr   = 1'b0;
    end else if (!end_go) begin
      tst_phase = nsdd_pkg::PH_FOUND;
      tst_ev    = nsdd_pkg::EV_END;
      tst_clr   = 1'b1;
    end else begin
      tst_phase = nsdd_pkg::PH_END;
      tst_ev    = nsdd_pkg::EV_DIP;
      tst_clr   = 1'b1;
    end
  end

  always_comb begin
    level_next    = level;
    total_next    = total;
    cnt_next      = cnt;
    phase_next    = phase;
    attempt_next  = attempt;
    finished_next = finished;
    ev            = nsdd_pkg::EV_NONE;
    absent        = 1'b0;
    do_fill       = 1'b0;

    if (s1_rearm) begin
      do_fill = 1'b1;
    end else begin
      level_next = level_upd;
      case (phase)
        nsdd_pkg::PH_WARM: begin
          cnt_next = cnt_inc;
          if (cnt_inc >= nsdd_pkg::CNT_W'(cfg.frame_length >> 1)) begin
            do_fill = 1'b1;
          end
        end
        nsdd_pkg::PH_FILL: begin
          total_next = total_upd;
          if (cnt_inc >= W_CNT) begin
            cnt_next   = '0;
            phase_next = tst_phase;
            ev         = tst_ev;
          end else begin
            cnt_next = cnt_inc;
          end
        end
        nsdd_pkg::PH_DIP: begin
          total_next = total_upd;
          if (cnt >= nsdd_pkg::CNT_W'(cfg.frame_length)) begin
            ev      = nsdd_pkg::EV_DIP_TIMEOUT;
            do_fill = 1'b1;
          end else begin
            cnt_next   = tst_clr ? '0 : cnt_inc;
            phase_next = tst_phase;
            ev         = tst_ev;
          end
        end
        nsdd_pkg::PH_END: begin
          total_next = total_upd;
          if (cnt >= nsdd_pkg::CNT_W'(cfg.null_length) + W_CNT) begin
            ev      = nsdd_pkg::EV_END_TIMEOUT;
            do_fill = 1'b1;
          end else begin
            cnt_next = cnt_inc;
            if (!end_go) begin
              phase_next = nsdd_pkg::PH_FOUND;
              ev         = nsdd_pkg::EV_END;
            end
          end
        end
        nsdd_pkg::PH_FOUND: begin
          phase_next = nsdd_pkg::PH_FOUND;
        end
        default: begin
          phase_next = nsdd_pkg::PH_FOUND;
        end
      endcase
    end

    // Restart from window fill; count an attempt while scanning.
    if (do_fill) begin
      total_next = '0;
      cnt_next   = '0;
      phase_next = nsdd_pkg::PH_FILL;
      if (cfg.scan_mode && !finished) begin
        if (attempt == nsdd_pkg::MAX_ATTEMPTS) begin
          absent        = 1'b1;
          finished_next = 1'b1;
          attempt_next  = '0;
        end else begin
          attempt_next = attempt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= '0;
      total    <= '0;
      cnt      <= '0;
      phase    <= nsdd_pkg::PH_WARM;
      attempt  <= '0;
      finished <= 1'b0;
    end else begin
      if (adv) begin
        level    <= level_next;
        total    <= total_next;
        cnt      <= cnt_next;
        phase    <= phase_next;
        attempt  <= attempt_next;
      end
      if (scan_clear) begin
        finished <= 1'b0;
      end else if (adv) begin
        finished <= finished_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      event_res     <= ev;
      signal_absent <= absent;
      window_sum    <= nsdd_pkg::SUM_OUT_W'(total_next);
      level_out     <= nsdd_pkg::LEVEL_OUT_W'(level_next >> nsdd_pkg::LEVEL_FRAC);
      sync_phase    <= nsdd_pkg::phase_code(phase_next);
    end
  end

endmodule

// ----- hw/rtl/null_symbol_dip_detector.sv -----
// Top level of the null-symbol dip detector: config registers, input stage,
// delay row of nsdd_cell, and nsdd_track. Depends on nsdd_pkg and nsdd_channels.
//
//   channel   modport  beat payload                                        handshake
//   samples   sink     opcode, sample_i, sample_q                          valid/ready
//   results   source   event_res, signal_absent, window_sum, level_out,    valid/ready
//                      sync_phase
//   cfg       sink     index, data                                         valid/ready
//
// One beat per clock sustained while results is ready; an accepted beat lands
// in the norm register, and from there its result is loaded into the result register.
// nsdd_track closes the per-beat recurrence of level, window sum and phase; the window
// is a row of WINDOW_LENGTH cells, shifted once per non-rearm beat in fill, dip, end.
// rst is synchronous; it clears control state and restores register defaults.
// A stalled results channel holds its beat; samples still fill the input stage.
module null_symbol_dip_detector #(
  parameter int WINDOW_LENGTH = 50,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  nsdd_in_if.sink     samples,
  nsdd_out_if.source  results,
  nsdd_cfg_if.sink    cfg
);

  localparam int NORM_W = SAMPLE_WIDTH + 1;

  nsdd_pkg::cfg_t      regs;
  logic                cfg_write;
  logic                scan_clear;
  logic                s1_valid;
  logic                s1_rearm;
  logic [NORM_W-1:0]   s1_norm;
  logic                s1_ready;
  logic                shift_en;
  logic [NORM_W-1:0]   taps [WINDOW_LENGTH+1];

  assign cfg.ready  = 1'b1;
  assign cfg_write  = cfg.valid && cfg.ready;
  assign scan_clear = cfg_write && (nsdd_pkg::cfg_reg_t'(cfg.index) == nsdd_pkg::REG_SCAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.frame_length <= nsdd_pkg::FRAME_RESET;
      regs.null_length  <= nsdd_pkg::NULL_RESET;
      regs.scan_mode    <= 1'b0;
      regs.level_shift  <= nsdd_pkg::SHIFT_RESET;
    end else if (cfg_write) begin
      case (nsdd_pkg::cfg_reg_t'(cfg.index))
        nsdd_pkg::REG_FRAME: regs.frame_length <= cfg.data[nsdd_pkg::FRAME_W-1:0];
        nsdd_pkg::REG_NULL:  regs.null_length  <= cfg.data[nsdd_pkg::NULL_W-1:0];
        nsdd_pkg::REG_SCAN:  regs.scan_mode    <= cfg.data[0];
        nsdd_pkg::REG_SHIFT: regs.level_shift  <= cfg.data[nsdd_pkg::SHIFT_W-1:0];
        default: regs.scan_mode <= regs.scan_mode;
      endcase
    end
  end

  nsdd_norm #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_norm (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (samples.valid),
    .in_ready   (samples.ready),
    .opcode     (samples.opcode),
    .sample_i   (samples.sample_i),
    .sample_q   (samples.sample_q),
    .down_ready (s1_ready),
    .s1_valid   (s1_valid),
    .s1_rearm   (s1_rearm),
    .s1_norm    (s1_norm)
  );

  // Newest norm enters at the head; the tail carries the one leaving the window.
  assign taps[0] = s1_norm;

  for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_row
    nsdd_cell #(
      .NORM_W (NORM_W)
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .d_in     (taps[k]),
      .q        (taps[k+1])
    );
  end

  nsdd_track #(
    .WINDOW_LENGTH (WINDOW_LENGTH),
    .SAMPLE_WIDTH  (SAMPLE_WIDTH)
  ) u_track (
    .clk           (clk),
    .rst           (rst),
    .cfg           (regs),
    .scan_clear    (scan_clear),
    .s1_valid      (s1_valid),
    .s1_rearm      (s1_rearm),
    .s1_norm       (s1_norm),
    .s1_ready      (s1_ready),
    .oldest        (taps[WINDOW_LENGTH]),
    .shift_en      (shift_en),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .event_res     (results.event_res),
    .signal_absent (results.signal_absent),
    .window_sum    (results.window_sum),
    .level_out     (results.level_out),
    .sync_phase    (results.sync_phase)
  );

endmodule
